>>> design/lidar_ray_grid_marker_macros.svh
// Assertion helpers used by the top-level design file
`ifndef LIDAR_RAY_GRID_MARKER_MACROS_SVH
`define LIDAR_RAY_GRID_MARKER_MACROS_SVH

// Same-cycle implication
`define RGM_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define RGM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/rgm_pkg.sv
package rgm_pkg;

    localparam int MAP_WIDTH   = 256;
    localparam int MAP_HEIGHT  = 256;
    localparam int ANGLE_STEPS = 360;
    localparam int CELLS       = MAP_WIDTH * MAP_HEIGHT;
    localparam int COL_W       = $clog2(MAP_WIDTH);
    localparam int ROW_W       = $clog2(MAP_HEIGHT);
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COUNT_W     = $clog2(CELLS + 1);
    localparam int FRAC        = 14;
    localparam int MAX_DIM     = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
    localparam int ACC_W       = $clog2((MAX_DIM + 1024) * (1 << FRAC)) + 1;
    localparam int TRIG_W      = FRAC + 2;
    localparam int RANGE_W     = 10;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = RANGE_W'(200);
    localparam longint PI_Q30  = 64'sd3373259426;

    typedef enum logic [1:0] {
        CELL_UNKNOWN  = 2'd0,
        CELL_FREE     = 2'd1,
        CELL_OBSTACLE = 2'd2
    } cell_t;

    typedef enum logic {
        OP_BEAM = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic read_en;
        logic step;
        logic clr_write;
        logic out_load;
    } rgm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic acc_read;
        logic acc_empty;
        logic last_step;
        logic clr_last;
    } rgm_status_t;

    typedef logic [FRAC:0] qsin_t [0:90];

    // Quarter-wave sine, Q2.30 Taylor series rounded to unsigned Q1.14 (elaboration only)
    // terms x^3/3! .. x^15/15!, each divided by (2n)(2n+1)
    function automatic qsin_t build_qsin();
        qsin_t  tab;
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int k = 0; k <= 90; k++) begin
            x    = (longint'(k) * PI_Q30) / 180;
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            term = (term * x2) >>> 30;
            term = term / 6;
            sum  = sum - term;
            term = (term * x2) >>> 30;
            term = term / 20;
            sum  = sum + term;
            term = (term * x2) >>> 30;
            term = term / 42;
            sum  = sum - term;
            term = (term * x2) >>> 30;
            term = term / 72;
            sum  = sum + term;
            term = (term * x2) >>> 30;
            term = term / 110;
            sum  = sum - term;
            term = (term * x2) >>> 30;
            term = term / 156;
            sum  = sum + term;
            term = (term * x2) >>> 30;
            term = term / 210;
            sum  = sum - term;
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = (FRAC + 1)'((sum + 32768) >>> 16);
        end
        return tab;
    endfunction

    localparam qsin_t QSIN = build_qsin();

    // Signed Q2.14 sine of a degree value below 720
    function automatic logic signed [TRIG_W-1:0] trig_q14(logic [9:0] deg_in);
        logic [9:0] deg;
        logic [9:0] idx;
        logic       neg;
        deg = (deg_in >= 10'(ANGLE_STEPS)) ? deg_in - 10'(ANGLE_STEPS) : deg_in;
        neg = 1'b0;
        if (deg <= 10'd90) begin
            idx = deg;
        end else if (deg <= 10'd180) begin
            idx = 10'd180 - deg;
        end else if (deg <= 10'd270) begin
            idx = deg - 10'd180;
            neg = 1'b1;
        end else begin
            idx = 10'd360 - deg;
            neg = 1'b1;
        end
        if (neg) begin
            return -$signed({1'b0, QSIN[idx[6:0]]});
        end
        return $signed({1'b0, QSIN[idx[6:0]]});
    endfunction

endpackage

>>> design/rgm_ctrl.sv
module rgm_ctrl
    import rgm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        out_free,
    input  rgm_status_t st,
    output rgm_cmd_t    cmd,
    output logic        s_ready
);

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_BEAM_RD = 6'b000100,
        ST_BEAM_WR = 6'b001000,
        ST_CELL_RD = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (st.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (st.acc_read) begin
                        state_next = ST_CELL_RD;
                    end else if (st.acc_empty) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_BEAM_RD;
                    end
                end
            end
            ST_BEAM_RD: begin
                cmd.read_en = 1'b1;
                state_next  = ST_BEAM_WR;
            end
            ST_BEAM_WR: begin
                cmd.step   = 1'b1;
                state_next = st.last_step ? ST_FINISH : ST_BEAM_RD;
            end
            ST_CELL_RD: begin
                cmd.read_en = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> design/rgm_dp.sv
module rgm_dp
    import rgm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_opcode,
    input  logic [7:0]         s_pos_x,
    input  logic [7:0]         s_pos_y,
    input  logic [8:0]         s_angle,
    input  logic [9:0]         s_distance,
    input  logic [7:0]         s_read_x,
    input  logic [7:0]         s_read_y,
    input  logic [RANGE_W-1:0] max_range,
    input  rgm_cmd_t           cmd,
    output rgm_status_t        st,
    output logic [1:0]         cell_out,
    output logic               complete_out,
    output logic               unknown_zero
);

    logic [1:0]  mem [0:CELLS-1];
    logic [1:0]  rd_data_reg;

    logic                    op_reg;
    logic signed [ACC_W-1:0] x_acc_reg;
    logic signed [ACC_W-1:0] y_acc_reg;
    logic signed [TRIG_W-1:0] cs_reg;
    logic signed [TRIG_W-1:0] sn_reg;
    logic [RANGE_W-1:0]      r_reg;
    logic [RANGE_W-1:0]      limit_reg;
    logic                    dist_zero_reg;
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic                    rd_ok_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;
    logic [1:0]              cell_out_reg;
    logic                    complete_out_reg;

    logic [8:0]         ang_mod;
    logic [RANGE_W-1:0] limit_in;
    logic signed [TRIG_W-1:0] sn_in;
    logic signed [TRIG_W-1:0] cs_in;
    logic               col_neg;
    logic               row_neg;
    logic               col_ok;
    logic               row_ok;
    logic               beam_ok;
    logic [COL_W-1:0]   col_idx;
    logic [ROW_W-1:0]   row_idx;
    logic [ADDR_W-1:0]  beam_addr;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;
    logic [1:0]         wdata;
    logic               we;

    // input decode at accept
    assign ang_mod  = (s_angle >= 9'(ANGLE_STEPS)) ? s_angle - 9'(ANGLE_STEPS) : s_angle;
    assign limit_in = (s_distance == '0) ? max_range : s_distance;
    assign sn_in    = trig_q14({1'b0, ang_mod});
    assign cs_in    = trig_q14({1'b0, ang_mod} + 10'd90);

    assign st.acc_read  = (s_opcode == OP_READ);
    assign st.acc_empty = (limit_in == '0);
    assign st.last_step = (r_reg == limit_reg);
    assign st.clr_last  = (clr_addr_reg == ADDR_W'(CELLS - 1));

    // ray position: truncate toward zero, keep cells inside the grid
    assign col_neg = x_acc_reg[ACC_W-1];
    assign row_neg = y_acc_reg[ACC_W-1];
    assign col_ok  = col_neg ? ((&x_acc_reg[ACC_W-1:FRAC]) && (|x_acc_reg[FRAC-1:0]))
                             : (x_acc_reg[ACC_W-1:FRAC] < MAP_WIDTH);
    assign row_ok  = row_neg ? ((&y_acc_reg[ACC_W-1:FRAC]) && (|y_acc_reg[FRAC-1:0]))
                             : (y_acc_reg[ACC_W-1:FRAC] < MAP_HEIGHT);
    assign beam_ok = col_ok && row_ok;
    assign col_idx = col_neg ? '0 : x_acc_reg[FRAC +: COL_W];
    assign row_idx = row_neg ? '0 : y_acc_reg[FRAC +: ROW_W];
    assign beam_addr = ADDR_W'(row_idx * MAP_WIDTH + col_idx);

    // memory port selection
    assign raddr = (op_reg == OP_READ) ? rd_addr_reg : beam_addr;
    assign waddr = cmd.clr_write ? clr_addr_reg : beam_addr;
    assign wdata = cmd.clr_write ? CELL_UNKNOWN
                 : ((!dist_zero_reg && st.last_step) ? CELL_OBSTACLE : CELL_FREE);
    assign we    = cmd.clr_write || (cmd.step && beam_ok);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.read_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    // item registers; the ray starts at its first cell (r = 1)
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= s_opcode;
            x_acc_reg     <= $signed({{(ACC_W-8-FRAC){1'b0}}, s_pos_x, {FRAC{1'b0}}})
                             + ACC_W'(cs_in);
            y_acc_reg     <= $signed({{(ACC_W-8-FRAC){1'b0}}, s_pos_y, {FRAC{1'b0}}})
                             + ACC_W'(sn_in);
            sn_reg        <= sn_in;
            cs_reg        <= cs_in;
            r_reg         <= RANGE_W'(1);
            limit_reg     <= limit_in;
            dist_zero_reg <= (s_distance == '0);
            rd_addr_reg   <= ADDR_W'(s_read_y * MAP_WIDTH + s_read_x);
            rd_ok_reg     <= (s_read_x < MAP_WIDTH) && (s_read_y < MAP_HEIGHT);
        end else if (cmd.step) begin
            x_acc_reg <= x_acc_reg + ACC_W'(cs_reg);
            y_acc_reg <= y_acc_reg + ACC_W'(sn_reg);
            r_reg     <= r_reg + RANGE_W'(1);
        end
    end

    // unknown cell counter and clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= COUNT_W'(CELLS);
            clr_addr_reg <= '0;
        end else begin
            if (cmd.clr_write) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.step && beam_ok && (rd_data_reg == CELL_UNKNOWN) && (count_reg != '0)) begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            cell_out_reg     <= ((op_reg == OP_READ) && rd_ok_reg) ? rd_data_reg : CELL_UNKNOWN;
            complete_out_reg <= (count_reg == '0);
        end
    end

    assign cell_out     = cell_out_reg;
    assign complete_out = complete_out_reg;
    assign unknown_zero = (count_reg == '0);

endmodule

>>> design/lidar_ray_grid_marker.sv
// Channel  | Handshake         | Payload
// ---------+-------------------+-------------------------------------------------
// input    | s_valid / s_ready | s_opcode s_pos_x s_pos_y s_angle s_distance
//          |                   | s_read_x s_read_y
// result   | m_valid / m_ready | m_cell_state m_map_complete
// config   | APB psel/penable  | paddr pwdata prdata (max_range at 0x0)
//
// A beam visits n cells, n = distance (or max_range when distance is 0):
// each cell is a read then a write on the grid memory.
// A cell read does one memory read. One item is in work at a time; the next is taken
// once its result sits in the output register.
// After reset all 65536 grid cells are swept to unknown, one cell a cycle,
// with s_ready low. A stalled m_ready holds the finished item in the last step.
`include "lidar_ray_grid_marker_macros.svh"

module lidar_ray_grid_marker
    import rgm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_pos_x,
    input  logic [7:0]  s_pos_y,
    input  logic [8:0]  s_angle,
    input  logic [9:0]  s_distance,
    input  logic [7:0]  s_read_x,
    input  logic [7:0]  s_read_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_cell_state,
    output logic        m_map_complete,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [RANGE_W-1:0] max_range_reg;
    logic               m_valid_reg;
    logic               out_free;
    logic               unknown_zero;
    rgm_cmd_t           cmd;
    rgm_status_t        st;

    // config register
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-RANGE_W){1'b0}}, max_range_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_range_reg <= MAX_RANGE_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            max_range_reg <= pwdata[RANGE_W-1:0];
        end
    end

    // result valid
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    rgm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .st       (st),
        .cmd      (cmd),
        .s_ready  (s_ready)
    );

    rgm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_opcode     (s_opcode),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_angle      (s_angle),
        .s_distance   (s_distance),
        .s_read_x     (s_read_x),
        .s_read_y     (s_read_y),
        .max_range    (max_range_reg),
        .cmd          (cmd),
        .st           (st),
        .cell_out     (m_cell_state),
        .complete_out (m_map_complete),
        .unknown_zero (unknown_zero)
    );

    // one request in work at a time
    `RGM_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_valid && s_ready, !s_ready)
    // once no cell is unknown, the unknown count stays at zero
    `RGM_ASSERT_NEXT(a_complete_sticks, aclk, aresetn, unknown_zero, unknown_zero)
    // no illegal cell code leaves the block
    `RGM_ASSERT_NOW(a_cell_code, aclk, aresetn, m_valid, m_cell_state != 2'd3)

endmodule
